/* hdl/bsxh_pkg.sv */
// ============================================================================
// bsxh_pkg
// Shared types and constants for the byte stream XOR-fold hash block.
// ============================================================================
package bsxh_pkg;

    // Payload widths of the two channels.
    localparam int BYTE_W  = 8;
    localparam int HASH_W  = 64;

    // Internal state widths.
    localparam int PATCH_W = 16;
    localparam int OFF_W   = 3;
    localparam int SHIFT_W = 7;

    // The bit offset advances by this amount for every byte.
    localparam logic [OFF_W:0]     OFF_STEP  = 4'd7;
    // The byte position advances by one byte for every folded patch byte.
    localparam logic [SHIFT_W-1:0] BYTE_STEP = 7'd8;

    // Handshake status of the output buffer, seen by the top level.
    typedef struct packed {
        logic can_load;
    } out_status_t;

endpackage

/* hdl/bsxh_ifs.sv */
// ============================================================================
// bsxh_msg_if / bsxh_digest_if
// Valid/ready channels for message bytes and finished hash words.
// ============================================================================
interface bsxh_msg_if import bsxh_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface bsxh_digest_if import bsxh_pkg::*;;
    logic              valid;
    logic              ready;
    logic [HASH_W-1:0] hash;

    modport source (output valid, output hash, input ready);
    modport sink   (input valid, input hash, output ready);
endinterface

/* hdl/bsxh_fold.sv */
// ============================================================================
// bsxh_fold
// Next-state logic: adds one byte into the patch and folds patch bytes into
// the accumulator, flushing the patch and clearing the state on the last byte.
// ============================================================================
module bsxh_fold import bsxh_pkg::*; #(
    parameter int WORD_BITS = 64
) (
    input  logic [WORD_BITS-1:0] acc_cur,
    input  logic [PATCH_W-1:0]   patch_cur,
    input  logic [OFF_W-1:0]     off_cur,
    input  logic [SHIFT_W-1:0]   shift_cur,
    input  logic [BYTE_W-1:0]    data_byte,
    input  logic                 last,
    output logic [WORD_BITS-1:0] acc_next,
    output logic [PATCH_W-1:0]   patch_next,
    output logic [OFF_W-1:0]     off_next,
    output logic [SHIFT_W-1:0]   shift_next,
    output logic [WORD_BITS-1:0] hash
);

    localparam logic [SHIFT_W-1:0] WORD_LIMIT = SHIFT_W'(WORD_BITS);

    typedef struct packed {
        logic [WORD_BITS-1:0] acc;
        logic [PATCH_W-1:0]   patch;
        logic [SHIFT_W-1:0]   shift;
    } fold_t;

    // Fold the low patch byte in at the next byte position. A byte that
    // lands exactly at the word width is dropped and the position wraps.
    function automatic fold_t emit(fold_t s);
        fold_t                r;
        logic [SHIFT_W-1:0]   pos;
        pos     = s.shift + BYTE_STEP;
        r       = s;
        if (pos < WORD_LIMIT)
        begin
            r.acc = s.acc ^ (WORD_BITS'(s.patch[BYTE_W-1:0]) << pos);
        end
        r.patch = s.patch >> BYTE_W;
        r.shift = (pos < WORD_LIMIT) ? pos : '0;
        return r;
    endfunction

    fold_t          s_add;
    fold_t          s_step;
    fold_t          s_flush1;
    fold_t          s_flush2;
    logic [OFF_W:0] off_sum;

    always_comb
    begin
        s_add.acc   = acc_cur;
        s_add.patch = patch_cur + (PATCH_W'(data_byte) << off_cur);
        s_add.shift = shift_cur;

        off_sum = {1'b0, off_cur} + OFF_STEP;
        s_step  = off_sum[OFF_W] ? emit(s_add) : s_add;

        // The patch never holds more than two bytes, so two flush steps cover it.
        s_flush1 = (s_step.patch != '0) ? emit(s_step) : s_step;
        s_flush2 = (s_flush1.patch != '0) ? emit(s_flush1) : s_flush1;

        hash = s_flush2.acc;

        if (last)
        begin
            acc_next   = '0;
            patch_next = '0;
            off_next   = '0;
            shift_next = '0;
        end
        else
        begin
            acc_next   = s_step.acc;
            patch_next = s_step.patch;
            off_next   = off_sum[OFF_W-1:0];
            shift_next = s_step.shift;
        end
    end

endmodule

/* hdl/bsxh_out_buf.sv */
// ============================================================================
// bsxh_out_buf
// Output register that holds a finished hash word until the receiver takes it.
// ============================================================================
module bsxh_out_buf import bsxh_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic [HASH_W-1:0]  hash_in,
    output out_status_t        status,
    bsxh_digest_if.source      digest
);

    logic              valid_reg;
    logic              valid_next;
    logic [HASH_W-1:0] hash_reg;

    // A new word may be loaded when the register is empty or drains this cycle.
    assign status.can_load = !valid_reg || digest.ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (digest.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hash_reg <= hash_in;
        end
    end

    assign digest.valid = valid_reg;
    assign digest.hash  = hash_reg;

endmodule

/* hdl/byte_stream_xor_fold_hash_top.sv */
// ============================================================================
// byte_stream_xor_fold_hash_top
// Byte stream XOR-fold hash: one message byte per word in, one hash per message.
// ============================================================================
// The msg channel carries one message byte per word together with a last flag
// that marks the final byte of a message. The digest channel returns one hash
// word per message, REG_BYTES*8 bits wide and zero-extended to 64 bits.
//
// A byte is taken into an input register on the edge where it is accepted.
// When it moves on, the fold logic adds it into the patch register, folds any
// completed patch byte into the accumulator and, for a last byte, flushes the
// patch and loads the hash into the output register, which drives digest.
//
// The block accepts one byte every cycle. The only stall comes from the output
// register: a last byte waits in the input register while a previous hash is
// still unread, and msg.ready drops for as long as it waits. Bytes that are not
// last never wait, since they produce no output word.
//
// Reset clears the input and output valid flags, the accumulator, the patch
// register, the bit offset and the byte position, so the next byte starts a
// new message.
// ============================================================================
module byte_stream_xor_fold_hash_top import bsxh_pkg::*; #(
    parameter int REG_BYTES = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    bsxh_msg_if.sink      msg,
    bsxh_digest_if.source digest
);

    localparam int WORD_BITS = REG_BYTES * 8;

    // Input register.
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_last_reg;
    logic              s1_adv;

    // Hash state.
    logic [WORD_BITS-1:0] acc_reg;
    logic [WORD_BITS-1:0] acc_next;
    logic [PATCH_W-1:0]   patch_reg;
    logic [PATCH_W-1:0]   patch_next;
    logic [OFF_W-1:0]     off_reg;
    logic [OFF_W-1:0]     off_next;
    logic [SHIFT_W-1:0]   shift_reg;
    logic [SHIFT_W-1:0]   shift_next;
    logic [WORD_BITS-1:0] fold_hash;

    out_status_t out_status;
    logic        out_load;

    // The held byte moves on unless it is a last byte facing a full output.
    assign s1_adv    = s1_valid_reg && (!s1_last_reg || out_status.can_load);
    assign msg.ready = !s1_valid_reg || s1_adv;
    assign out_load  = s1_adv && s1_last_reg;

    always_comb
    begin
        if (msg.ready)
        begin
            s1_valid_next = msg.valid;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg.valid && msg.ready)
        begin
            s1_byte_reg <= msg.data_byte;
            s1_last_reg <= msg.last;
        end
    end

    bsxh_fold #(
        .WORD_BITS (WORD_BITS)
    ) u_fold (
        .acc_cur    (acc_reg),
        .patch_cur  (patch_reg),
        .off_cur    (off_reg),
        .shift_cur  (shift_reg),
        .data_byte  (s1_byte_reg),
        .last       (s1_last_reg),
        .acc_next   (acc_next),
        .patch_next (patch_next),
        .off_next   (off_next),
        .shift_next (shift_next),
        .hash       (fold_hash)
    );

    // The hash state only moves when the held byte is consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            patch_reg <= '0;
            off_reg   <= '0;
            shift_reg <= '0;
        end
        else if (s1_adv)
        begin
            acc_reg   <= acc_next;
            patch_reg <= patch_next;
            off_reg   <= off_next;
            shift_reg <= shift_next;
        end
    end

    bsxh_out_buf u_out_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (out_load),
        .hash_in (HASH_W'(fold_hash)),
        .status  (out_status),
        .digest  (digest)
    );

    // A held byte that cannot move leaves the hash state untouched.
    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> $stable(acc_reg) && $stable(patch_reg)
            && $stable(off_reg) && $stable(shift_reg))
        else $error("hash state changed while the input register was stalled");

    // A byte that is not last advances the bit offset by seven, modulo eight.
    a_offset_step: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && !s1_last_reg |=> off_reg == OFF_W'($past(off_reg) + OFF_W'(OFF_STEP)))
        else $error("bit offset did not advance by seven");

    // A last byte produces an output word and leaves a clean state behind.
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> digest.valid && acc_reg == '0 && patch_reg == '0
            && off_reg == '0 && shift_reg == '0)
        else $error("last byte did not emit a hash and clear the state");

    // The byte position is always byte aligned and inside the word.
    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        shift_reg[2:0] == 3'd0 && shift_reg < SHIFT_W'(WORD_BITS))
        else $error("byte position out of range");

endmodule

/* dv/bsxh_hash_checker.sv */
// ============================================================================
// bsxh_hash_checker
// Watches the msg and digest channels, predicts each hash and compares it.
// ============================================================================
// Every accepted msg word is folded into a private copy of the hash state.
// A word with last set queues the expected hash. Every accepted digest word is
// compared with the oldest queued hash.
// ============================================================================
module bsxh_hash_checker import bsxh_pkg::*; #(
    parameter int REG_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    bsxh_msg_if         msg,
    bsxh_digest_if      digest,
    output int unsigned fail_count,
    output int unsigned hashes_pending
);

    localparam int          WORD_BITS  = REG_BYTES * 8;
    localparam int unsigned MAX_REPORT = 10;

    logic [HASH_W-1:0]  acc;
    logic [PATCH_W-1:0] patch;
    logic [OFF_W-1:0]   bit_off;
    logic [SHIFT_W-1:0] byte_pos;
    logic [HASH_W-1:0]  hash_expected[$];

    // Fold the low patch byte in one byte above the stored position. A byte
    // that would land at the word width is dropped and the position wraps.
    function automatic void fold_patch_byte();
        int unsigned pos;
        pos = byte_pos + BYTE_STEP;
        if (pos < WORD_BITS)
        begin
            acc ^= HASH_W'(patch[7:0]) << pos;
        end
        patch = patch >> 8;
        if (pos >= WORD_BITS)
        begin
            pos = 0;
        end
        byte_pos = SHIFT_W'(pos);
    endfunction

    function automatic void absorb_byte(input logic [BYTE_W-1:0] data_byte,
                                        input logic last);
        logic [OFF_W:0] off_sum;
        off_sum = {1'b0, bit_off};
        patch   = patch + (PATCH_W'(data_byte) << off_sum);
        off_sum = off_sum + OFF_STEP;
        if (off_sum >= 4'd8)
        begin
            off_sum = off_sum - 4'd8;
            fold_patch_byte();
        end
        bit_off = off_sum[OFF_W-1:0];
        if (last)
        begin
            while (patch != '0)
            begin
                fold_patch_byte();
            end
            hash_expected.push_back(acc);
            acc      = '0;
            patch    = '0;
            bit_off  = '0;
            byte_pos = '0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc            = '0;
            patch          = '0;
            bit_off        = '0;
            byte_pos       = '0;
            hash_expected.delete();
            fail_count     = 0;
            hashes_pending = 0;
        end
        else
        begin
            // The msg side goes first; a hash can never leave on the edge
            // that accepted its last byte.
            if (msg.valid && msg.ready)
            begin
                absorb_byte(msg.data_byte, msg.last);
            end
            if (digest.valid && digest.ready)
            begin
                if (hash_expected.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORT)
                    begin
                        $display("ERROR: unexpected hash %h, none pending", digest.hash);
                    end
                end
                else
                begin
                    if (digest.hash !== hash_expected[0])
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORT)
                        begin
                            $display("ERROR: hash mismatch, expected %h, got %h",
                                     hash_expected[0], digest.hash);
                        end
                    end
                    void'(hash_expected.pop_front());
                end
            end
            hashes_pending = hash_expected.size();
        end
    end

endmodule

/* dv/tb_byte_stream_xor_fold_hash_top.sv */
// ============================================================================
// tb_byte_stream_xor_fold_hash_top
// Directed and random messages through the XOR-fold hash block.
// ============================================================================
// The top drives message bytes on msg and takes hash words from digest, both
// with random per-word delays and stretches without any. The checker beside
// the block predicts every hash and counts mismatches; this module only makes
// stimulus, watches for a hang and gives the verdict.
// ============================================================================
module tb_byte_stream_xor_fold_hash_top;
    import bsxh_pkg::*;

    localparam int          REG_BYTES   = 8;
    // Random part stops once this many bytes have been sent.
    localparam int unsigned BYTE_TARGET = 1650;
    // The receiver holds off for this long once it has taken HOLD_AT words.
    localparam int unsigned HOLD_AT     = 40;
    localparam int unsigned HOLD_CYCLES = 300;
    // Cycles without any accepted word before the run is declared hung. The
    // longest correct quiet stretch is the hold above plus a few gaps.
    localparam int unsigned IDLE_LIMIT  = 2000;
    // Settling time after the last hash, leaving room for any stray word.
    localparam int unsigned DRAIN_CYCLES = 8;

    // Byte content kinds for a random message.
    typedef enum int {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZEROS,
        FILL_ONEHOT
    } fill_kind_t;

    logic        clk;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned hashes_pending;
    int unsigned bytes_sent;
    // When set, the sender offers words back to back.
    logic        send_burst;

    bsxh_msg_if    msg();
    bsxh_digest_if digest();

    byte_stream_xor_fold_hash_top #(
        .REG_BYTES (REG_BYTES)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg),
        .digest (digest)
    );

    bsxh_hash_checker #(
        .REG_BYTES (REG_BYTES)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .msg            (msg),
        .digest         (digest),
        .fail_count     (fail_count),
        .hashes_pending (hashes_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one byte after a random gap and hold it until it is accepted.
    // A gap of zero keeps valid high, so back-to-back words never see valid
    // lowered and raised in the same step.
    task automatic send_byte(input logic [BYTE_W-1:0] data_byte, input logic last);
        int unsigned gap;
        gap = send_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            msg.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg.valid     <= 1'b1;
        msg.data_byte <= data_byte;
        msg.last      <= last;
        do
        begin
            @(posedge clk);
        end
        while (!(msg.valid && msg.ready));
        bytes_sent++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte(input fill_kind_t kind);
        logic [BYTE_W-1:0] value;
        case (kind)
            FILL_ONES:   value = 8'hFF;
            FILL_ZEROS:  value = 8'h00;
            FILL_ONEHOT: value = 8'h01 << $urandom_range(0, 7);
            default:     value = BYTE_W'($urandom);
        endcase
        return value;
    endfunction

    // A whole message: len bytes of one fill kind, the final one marked last.
    task automatic send_message(input int unsigned len, input fill_kind_t kind);
        for (int unsigned i = 0; i < len; i++)
        begin
            send_byte(pick_byte(kind), i == len - 1);
        end
    endtask

    // Stimulus and verdict.
    initial
    begin : stimulus
        int unsigned len;
        int unsigned roll;
        fill_kind_t  kind;

        rst_n         <= 1'b0;
        msg.valid     <= 1'b0;
        msg.data_byte <= '0;
        msg.last      <= 1'b0;
        send_burst    = 1'b0;
        bytes_sent    = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. One-byte messages at both byte extremes: the byte
        // stays in the patch and is only placed by the flush.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // A byte with only the top bit set followed by a last byte, so the
        // patch carries into its high byte before the flush.
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        // A long all-ones message: the byte position runs up to the word
        // width, the patch byte that would land there is dropped, and the
        // position wraps back to the bottom of the accumulator.
        send_message(20, FILL_ONES);

        // Random part. Mostly short messages, some that wrap the accumulator
        // once or more, and a few long ones.
        while (bytes_sent < BYTE_TARGET)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                len = $urandom_range(1, 12);
            end
            else if (roll < 95)
            begin
                len = $urandom_range(13, 30);
            end
            else
            begin
                len = $urandom_range(31, 64);
            end
            roll = $urandom_range(0, 9);
            if (roll < 7)
            begin
                kind = FILL_RANDOM;
            end
            else if (roll == 7)
            begin
                kind = FILL_ONES;
            end
            else if (roll == 8)
            begin
                kind = FILL_ZEROS;
            end
            else
            begin
                kind = FILL_ONEHOT;
            end
            // About a quarter of the messages go out with no gaps at all.
            send_burst = ($urandom_range(0, 3) == 0);
            send_message(len, kind);
        end
        msg.valid <= 1'b0;

        // Wait until every predicted hash has arrived. Sampling on the falling
        // edge keeps the read clear of the checker's update at the rising one.
        do
        begin
            @(negedge clk);
        end
        while (hashes_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("byte_stream_xor_fold_hash_top test passed");
        end
        else
        begin
            $display("byte_stream_xor_fold_hash_top test failed");
        end
        $finish;
    end

    // Receiver. Each hash word waits a random delay before ready rises,
    // with stretches of no waiting. Once, it holds ready low for a long time
    // while the sender keeps going, so a last byte gets stuck in the block's
    // input register and msg.ready drops.
    initial
    begin : digest_side
        int unsigned stall;
        int unsigned words_taken;
        logic        take_fast;

        digest.ready <= 1'b0;
        words_taken  = 0;
        take_fast    = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (words_taken == HOLD_AT)
            begin
                stall = HOLD_CYCLES;
            end
            else if (take_fast)
            begin
                stall = 0;
            end
            else
            begin
                stall = $urandom_range(0, 8);
            end
            if (stall > 0)
            begin
                digest.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            digest.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!(digest.valid && digest.ready));
            words_taken++;
            if (words_taken % 16 == 0)
            begin
                take_fast = ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Hang detection: count cycles in which neither channel moves a word.
    initial
    begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((msg.valid && msg.ready) || (digest.valid && digest.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("byte_stream_xor_fold_hash_top test failed");
        $finish;
    end

endmodule
